@@ rtl/tcrb_pkg.sv @@
// tcrb_pkg: shared constants, codes and payload types of the terminal byte ring buffer
`default_nettype none
package tcrb_pkg;

	localparam int DEPTH     = 1024;
	localparam int MAX_BURST = 64;

	localparam int IDX_W   = $clog2(DEPTH);
	localparam int SIZE_W  = $clog2(DEPTH) + 1;
	localparam int CFG_W   = 11;
	localparam int CNT_W   = 10;
	localparam int AMT_W   = 10;
	localparam int OCC_W   = 10;
	localparam int BURST_W = $clog2(MAX_BURST + 1);
	localparam int WIDE_W  = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

	localparam int SIZE_RST = (DEPTH < 1024) ? DEPTH : 1024;

	localparam logic [2:0] K_PUT   = 3'd0;
	localparam logic [2:0] K_GET   = 3'd1;
	localparam logic [2:0] K_FLUSH = 3'd2;
	localparam logic [2:0] K_SCAN  = 3'd3;
	localparam logic [2:0] K_CLEAR = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [2:0]       kind;
		logic [7:0]       data_in;
		logic [CNT_W-1:0] count;
		logic [7:0]       mask;
	} req_t;

	typedef struct packed {
		logic [7:0]       data_out;
		logic [1:0]       status;
		logic [AMT_W-1:0] amount;
		logic [OCC_W-1:0] occupancy;
		logic             last;
	} rsp_t;

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic [7:0]       wr_data;
	} mem_req_t;

	typedef struct packed {
		logic [SIZE_W-1:0] a;
		logic [SIZE_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [SIZE_W:0]   sum;
		logic [SIZE_W-1:0] wrap;
	} alu_rsp_t;

endpackage
`default_nettype wire

@@ rtl/tty_char_ring_buffer.sv @@
// tty_char_ring_buffer: top level of the terminal byte ring buffer
//
// request channel (req_valid, req_ready, req): one operation per transfer,
//   put, get burst, flush, scan with mask or clear
// response channel (rsp_valid, rsp_ready, rsp): one result per transfer, the
//   final result of an operation carries last
// config channel (cfg_valid, cfg_ready, cfg_data): writes buffer_size, which is
//   saturated to 2..DEPTH, and empties the buffer as clear does
// single results: put, flush, clear, empty or zero-count get, mask-free scan
//   and unused kinds pass through EXEC to EMIT, which writes the output
//   register; the next request is taken once the sequencer is back in IDLE
// get: each byte takes a read state GRD (address) and an emit state GEM (data),
//   set by the single read port of the byte store
// scan with mask: each byte examined takes a read state SCK and a compare state
//   STS; the result comes when a byte meets the mask or when the run ends with
//   no such byte; req_ready is low while busy
// reset: indices and fill count go to zero, buffer_size to 1024, store contents
//   stay undefined; no clearing pass, so the block is ready at once
// receiver stall: the result waits in the output register and the sequencer
//   holds its state until that register is free again
`default_nettype none
module tty_char_ring_buffer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  tcrb_pkg::req_t             req,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output tcrb_pkg::rsp_t             rsp,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [tcrb_pkg::CFG_W-1:0] cfg_data
);
	import tcrb_pkg::*;

	logic [SIZE_W-1:0] size_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic     cfg_wr;
	logic     out_free;
	logic     push;
	rsp_t     push_item;
	mem_req_t mem_req;
	logic [7:0] rdata;
	alu_req_t alu_req;
	alu_rsp_t alu_rsp;

	// config writes are only taken between operations, with no request offered
	// and no result waiting
	assign cfg_ready = req_ready && !req_valid && !rsp_valid_q;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// effective size register, saturated on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_W'(SIZE_RST);
		end else if (cfg_wr) begin
			if (cfg_data < CFG_W'(2)) begin
				size_q <= SIZE_W'(2);
			end else if (int'(cfg_data) > DEPTH) begin
				size_q <= SIZE_W'(DEPTH);
			end else begin
				size_q <= SIZE_W'(cfg_data);
			end
		end
	end

	// output register parts the sequencer from the receiver
	assign out_free = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (push) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			rsp_q <= push_item;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	tcrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_ready (req_ready),
		.clr       (cfg_wr),
		.size      (size_q),
		.out_free  (out_free),
		.push      (push),
		.push_item (push_item),
		.mem_req   (mem_req),
		.rdata     (rdata),
		.alu_req   (alu_req),
		.alu_rsp   (alu_rsp)
	);

	tcrb_alu u_alu (
		.req  (alu_req),
		.size (size_q),
		.rsp  (alu_rsp)
	);

	tcrb_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("result pushed into a full output register");

	// usable capacity is one less than the store size
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (int'(rsp.occupancy) < int'(size_q)))
		else $error("occupancy beyond capacity");

	// a burst only continues while bytes remain
	a_burst_more: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.last) |-> (rsp.occupancy != '0))
		else $error("burst continues from an empty buffer");

	// the sequencer is busy right after taking a request
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken while an operation is under way");

endmodule
`default_nettype wire

@@ rtl/tcrb_alu.sv @@
// tcrb_alu: shared index adder with modulo-size wrap
`default_nettype none
module tcrb_alu (
	input  tcrb_pkg::alu_req_t          req,
	input  logic [tcrb_pkg::SIZE_W-1:0] size,
	output tcrb_pkg::alu_rsp_t          rsp
);
	import tcrb_pkg::*;

	logic [SIZE_W:0] sum;

	assign sum = {1'b0, req.a} + {1'b0, req.b};

	always_comb begin
		rsp.sum = sum;
		if (sum >= {1'b0, size}) begin
			rsp.wrap = SIZE_W'(sum - {1'b0, size});
		end else begin
			rsp.wrap = SIZE_W'(sum);
		end
	end

endmodule
`default_nettype wire

@@ rtl/tcrb_store.sv @@
// tcrb_store: byte store, one write port and one registered read port
`default_nettype none
module tcrb_store (
	input  logic               clk,
	input  tcrb_pkg::mem_req_t req,
	output logic [7:0]         rdata
);
	import tcrb_pkg::*;

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rdata <= mem[req.rd_addr];
		end
	end

endmodule
`default_nettype wire

@@ rtl/tcrb_ctrl.sv @@
// tcrb_ctrl: operation sequencer, ring indices and fill counter
`default_nettype none
module tcrb_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	input  tcrb_pkg::req_t              req,
	output logic                        req_ready,
	input  logic                        clr,
	input  logic [tcrb_pkg::SIZE_W-1:0] size,
	input  logic                        out_free,
	output logic                        push,
	output tcrb_pkg::rsp_t              push_item,
	output tcrb_pkg::mem_req_t          mem_req,
	input  logic [7:0]                  rdata,
	output tcrb_pkg::alu_req_t          alu_req,
	input  tcrb_pkg::alu_rsp_t          alu_rsp
);
	import tcrb_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_EMIT = 3'd2;
	localparam logic [2:0] S_GRD  = 3'd3;
	localparam logic [2:0] S_GEM  = 3'd4;
	localparam logic [2:0] S_SCK  = 3'd5;
	localparam logic [2:0] S_STS  = 3'd6;

	logic [2:0]         state_q;
	logic [IDX_W-1:0]   read_q;
	logic [IDX_W-1:0]   write_q;
	logic [IDX_W-1:0]   fill_q;
	req_t               req_q;
	rsp_t               res_q;
	logic [BURST_W-1:0] want_q;
	logic [BURST_W-1:0] n_q;
	logic [SIZE_W-1:0]  p_q;
	logic [SIZE_W-1:0]  lim_q;

	logic [IDX_W-1:0]   wrapped;
	logic               full;
	logic               fin;
	logic [WIDE_W-1:0]  drop;
	logic [BURST_W-1:0] want;
	logic [SIZE_W-1:0]  lim;
	logic               p_in_run;
	logic               hit;

	assign req_ready = (state_q == S_IDLE);
	assign wrapped   = IDX_W'(alu_rsp.wrap);
	assign full      = (wrapped == read_q);
	assign fin       = (BURST_W'(n_q + 1'b1) == want_q) || (wrapped == write_q);
	assign p_in_run  = (p_q < lim_q);
	assign hit       = ((rdata & req_q.mask) != 8'd0);

	// flush drops no more than is held, get is capped at one burst; lim ends the scan run
	always_comb begin
		if (WIDE_W'(req_q.count) < WIDE_W'(fill_q)) begin
			drop = WIDE_W'(req_q.count);
		end else begin
			drop = WIDE_W'(fill_q);
		end
		if (req_q.count > CNT_W'(MAX_BURST)) begin
			want = BURST_W'(MAX_BURST);
		end else begin
			want = BURST_W'(req_q.count);
		end
		if (write_q < read_q) begin
			lim = size;
		end else begin
			lim = SIZE_W'(write_q);
		end
	end

	// operand selection for the shared adder
	always_comb begin
		alu_req = '0;
		case (state_q)
			S_EXEC: begin
				if (req_q.kind == K_PUT) begin
					alu_req.a = SIZE_W'(write_q);
					alu_req.b = SIZE_W'(1);
				end else begin
					alu_req.a = SIZE_W'(read_q);
					alu_req.b = SIZE_W'(drop);
				end
			end
			S_GEM: begin
				alu_req.a = SIZE_W'(read_q);
				alu_req.b = SIZE_W'(1);
			end
			S_STS: begin
				alu_req.a = p_q;
				alu_req.b = SIZE_W'(1);
			end
			default: begin
				alu_req = '0;
			end
		endcase
	end

	always_comb begin
		mem_req.rd_en   = (state_q == S_GRD) || ((state_q == S_SCK) && p_in_run);
		mem_req.rd_addr = (state_q == S_SCK) ? IDX_W'(p_q) : read_q;
		mem_req.wr_en   = (state_q == S_EXEC) && (req_q.kind == K_PUT) && !full;
		mem_req.wr_addr = write_q;
		mem_req.wr_data = req_q.data_in;
	end

	assign push = ((state_q == S_EMIT) || (state_q == S_GEM)) && out_free;

	always_comb begin
		if (state_q == S_GEM) begin
			push_item.data_out  = rdata;
			push_item.status    = ST_OK;
			push_item.amount    = '0;
			push_item.occupancy = OCC_W'(fill_q - 1'b1);
			push_item.last      = fin;
		end else begin
			push_item = res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			read_q  <= '0;
			write_q <= '0;
			fill_q  <= '0;
		end else if (clr) begin
			read_q  <= '0;
			write_q <= '0;
			fill_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_EMIT;
					case (req_q.kind)
						K_PUT: begin
							if (!full) begin
								write_q <= wrapped;
								fill_q  <= fill_q + 1'b1;
							end
						end
						K_GET: begin
							if ((want != '0) && (read_q != write_q)) begin
								state_q <= S_GRD;
							end
						end
						K_FLUSH: begin
							read_q <= wrapped;
							fill_q <= fill_q - IDX_W'(drop);
						end
						K_SCAN: begin
							if (req_q.mask != 8'd0) begin
								state_q <= S_SCK;
							end
						end
						K_CLEAR: begin
							read_q  <= '0;
							write_q <= '0;
							fill_q  <= '0;
						end
						default: begin
							state_q <= S_EMIT;
						end
					endcase
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_GRD: begin
					state_q <= S_GEM;
				end
				S_GEM: begin
					if (out_free) begin
						read_q  <= wrapped;
						fill_q  <= fill_q - 1'b1;
						state_q <= fin ? S_IDLE : S_GRD;
					end
				end
				S_SCK: begin
					state_q <= p_in_run ? S_STS : S_EMIT;
				end
				S_STS: begin
					state_q <= hit ? S_EMIT : S_SCK;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && req_valid) begin
			req_q <= req;
		end
		case (state_q)
			S_EXEC: begin
				res_q.data_out  <= 8'd0;
				res_q.status    <= ST_OK;
				res_q.amount    <= '0;
				res_q.occupancy <= OCC_W'(fill_q);
				res_q.last      <= 1'b1;
				want_q          <= want;
				n_q             <= '0;
				p_q             <= SIZE_W'(read_q);
				lim_q           <= lim;
				case (req_q.kind)
					K_PUT: begin
						if (full) begin
							res_q.status <= ST_FULL;
						end else begin
							res_q.occupancy <= OCC_W'(fill_q + 1'b1);
						end
					end
					K_GET: begin
						if ((want != '0) && (read_q == write_q)) begin
							res_q.status <= ST_EMPTY;
						end
					end
					K_FLUSH: begin
						res_q.amount    <= AMT_W'(drop);
						res_q.occupancy <= OCC_W'(fill_q - IDX_W'(drop));
					end
					K_SCAN: begin
						res_q.amount <= AMT_W'(lim - SIZE_W'(read_q));
					end
					K_CLEAR: begin
						res_q.occupancy <= '0;
					end
					default: begin
						res_q.amount <= '0;
					end
				endcase
			end
			S_GEM: begin
				if (out_free) begin
					n_q <= BURST_W'(n_q + 1'b1);
				end
			end
			S_SCK: begin
				if (!p_in_run) begin
					res_q.amount <= AMT_W'(p_q - SIZE_W'(read_q));
				end
			end
			S_STS: begin
				if (hit) begin
					res_q.amount <= AMT_W'(p_q - SIZE_W'(read_q));
				end else begin
					p_q <= SIZE_W'(alu_rsp.sum);
				end
			end
			default: begin
				n_q <= n_q;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ tb/tb_tty_char_ring_buffer.sv @@
// tb_tty_char_ring_buffer: self-checking testbench for the terminal byte ring buffer
module tb_tty_char_ring_buffer;
	timeunit 1ns;
	timeprecision 1ps;

	import tcrb_pkg::*;

	// kinds with no operation behind them, answered with a plain ok result
	localparam logic [2:0] K_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] K_UNUSED_LAST  = 3'd7;

	// receiver behaviour
	localparam int RX_ALWAYS  = 0;
	localparam int RX_RANDOM  = 1;
	localparam int RX_PATTERN = 2;

	// longest legitimate stretch without a transfer is a masked scan over a
	// full store plus the long receiver hold-off, both well under this
	localparam int QUIET_LIMIT = 20000;
	localparam int PRINT_LIMIT = 60;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_ready;
	req_t             req       = '0;
	logic             rsp_valid;
	logic             rsp_ready = 1'b0;
	rsp_t             rsp;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data  = '0;

	tty_char_ring_buffer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// ---------------------------------------------------------------
	// predicted ring state, kept alongside the block
	// ---------------------------------------------------------------
	logic [7:0]   ring_mem [DEPTH];
	int unsigned  ring_rd       = 0;
	int unsigned  ring_wr       = 0;
	int unsigned  ring_held     = 0;
	int unsigned  ring_size_reg = 1024;

	// results still owed by the block, oldest first
	rsp_t awaited_results [$];

	int mismatch_count  = 0;
	int results_checked = 0;

	// sender idling: bursts of random length, gaps of random length bounded by gap_max
	int gap_max    = 0;
	int burst_left = 0;

	// receiver stalling
	int rx_mode      = RX_ALWAYS;
	int hold_request = 0;

	function automatic void empty_ring();
		ring_rd   = 0;
		ring_wr   = 0;
		ring_held = 0;
	endfunction

	function automatic void queue_result(input logic [7:0] data, input logic [1:0] status,
			input int unsigned amount, input bit fin);
		rsp_t r;
		r.data_out  = data;
		r.status    = status;
		r.amount    = AMT_W'(amount);
		r.occupancy = OCC_W'(ring_held);
		r.last      = fin;
		awaited_results.push_back(r);
	endfunction

	// works out every result of one accepted operation and moves the ring on
	function automatic void predict_ring_op(input req_t op);
		int unsigned sz, want, n, drop, lim, p, nxt;
		logic [7:0]  b;
		sz = ring_size_reg;
		if (sz < 2) sz = 2;
		if (sz > DEPTH) sz = DEPTH;
		if (ring_rd >= sz || ring_wr >= sz) empty_ring();
		case (op.kind)
			K_PUT: begin
				nxt = (ring_wr + 1 >= sz) ? 0 : ring_wr + 1;
				if (nxt == ring_rd) begin
					queue_result(8'd0, ST_FULL, 0, 1'b1);
				end else begin
					ring_mem[ring_wr] = op.data_in;
					ring_wr = nxt;
					ring_held++;
					queue_result(8'd0, ST_OK, 0, 1'b1);
				end
			end
			K_GET: begin
				want = (op.count > MAX_BURST) ? MAX_BURST : op.count;
				n = 0;
				if (want == 0) begin
					queue_result(8'd0, ST_OK, 0, 1'b1);
				end else if (ring_rd == ring_wr) begin
					queue_result(8'd0, ST_EMPTY, 0, 1'b1);
				end else begin
					while (n < want && ring_rd != ring_wr) begin
						b = ring_mem[ring_rd];
						ring_rd = (ring_rd + 1 >= sz) ? 0 : ring_rd + 1;
						ring_held--;
						queue_result(b, ST_OK, 0, (n + 1 == want) || (ring_rd == ring_wr));
						n++;
					end
				end
			end
			K_FLUSH: begin
				drop = (op.count < ring_held) ? op.count : ring_held;
				p = ring_rd + drop;
				if (p >= sz) p -= sz;
				ring_rd = p;
				ring_held -= drop;
				queue_result(8'd0, ST_OK, drop, 1'b1);
			end
			K_SCAN: begin
				// run ends at the store end when the held bytes wrap
				lim = (ring_wr < ring_rd) ? sz : ring_wr;
				p = ring_rd;
				if (op.mask != 8'd0) begin
					while (p < lim && (ring_mem[p] & op.mask) == 8'd0) p++;
				end else begin
					p = lim;
				end
				queue_result(8'd0, ST_OK, p - ring_rd, 1'b1);
			end
			K_CLEAR: begin
				empty_ring();
				queue_result(8'd0, ST_OK, 0, 1'b1);
			end
			default: begin
				queue_result(8'd0, ST_OK, 0, 1'b1);
			end
		endcase
	endfunction

	task automatic log_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatch_count < PRINT_LIMIT)
			$display("[%0t] mismatch at result %0d: %s got 0x%0h want 0x%0h",
				$realtime, results_checked, what, got, want);
		mismatch_count++;
	endtask

	function automatic req_t ring_op(input logic [2:0] kind, input logic [7:0] data,
			input logic [9:0] count, input logic [7:0] mask);
		req_t op;
		op.kind    = kind;
		op.data_in = data;
		op.count   = count;
		op.mask    = mask;
		return op;
	endfunction

	// random operation; fill_bias leans towards puts, otherwise towards gets
	function automatic req_t random_op(input bit fill_bias);
		req_t        op;
		int unsigned roll;
		case ($urandom_range(0, 5))
			0:       op.data_in = 8'd0;
			1, 2:    op.data_in = 8'(1 << $urandom_range(0, 7));
			default: op.data_in = 8'($urandom);
		endcase
		case ($urandom_range(0, 4))
			0:       op.mask = 8'd0;
			1, 2:    op.mask = 8'(1 << $urandom_range(0, 7));
			default: op.mask = 8'($urandom);
		endcase
		if ($urandom_range(0, 7) == 0)
			op.count = 10'($urandom);
		else
			op.count = 10'($urandom_range(0, fill_bias ? 6 : 70));
		roll = $urandom_range(0, 99);
		if (fill_bias) begin
			if (roll < 60)      op.kind = K_PUT;
			else if (roll < 72) op.kind = K_GET;
			else if (roll < 78) op.kind = K_FLUSH;
			else if (roll < 94) op.kind = K_SCAN;
			else if (roll < 96) op.kind = K_CLEAR;
			else                op.kind = 3'($urandom_range(K_UNUSED_FIRST, K_UNUSED_LAST));
		end else begin
			if (roll < 22)      op.kind = K_PUT;
			else if (roll < 62) op.kind = K_GET;
			else if (roll < 72) op.kind = K_FLUSH;
			else if (roll < 92) op.kind = K_SCAN;
			else if (roll < 95) op.kind = K_CLEAR;
			else                op.kind = 3'($urandom_range(K_UNUSED_FIRST, K_UNUSED_LAST));
		end
		return op;
	endfunction

	// ---------------------------------------------------------------
	// request side: called at a falling edge, returns at a falling edge
	// ---------------------------------------------------------------
	task automatic send_op(input req_t op);
		req       <= op;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_ready !== 1'b1);
		predict_ring_op(op);
		@(negedge clk);
		// valid stays high into the next transfer unless a gap starts here
		if (gap_max != 0) begin
			if (burst_left == 0) begin
				req_valid <= 1'b0;
				repeat ($urandom_range(1, gap_max)) @(negedge clk);
				burst_left = $urandom_range(0, 12);
			end else begin
				burst_left--;
			end
		end
	endtask

	// sender pauses until every owed result has been taken
	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(negedge clk); while (awaited_results.size() != 0);
	endtask

	// register writes only happen with the block idle
	task automatic write_buffer_size(input logic [CFG_W-1:0] value);
		wait_drained();
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		ring_size_reg = value;
		empty_ring();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// ---------------------------------------------------------------
	// response side: stall pattern plus an optional long hold-off
	// ---------------------------------------------------------------
	logic [15:0] rx_pattern = 16'b1011_0111_0010_1101;
	int unsigned rx_cycle   = 0;
	int          hold_left  = 0;

	always @(negedge clk) begin
		rx_cycle++;
		if (hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_RANDOM:  rsp_ready <= ($urandom_range(0, 3) != 0);
				RX_PATTERN: rsp_ready <= rx_pattern[rx_cycle % 16];
				default:    rsp_ready <= 1'b1;
			endcase
		end
	end

	// every result transfer is held against the oldest prediction
	always @(posedge clk) begin : check_results
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (awaited_results.size() == 0) begin
				log_mismatch("result with nothing awaited", 32'(rsp), 32'd0);
			end else begin
				want = awaited_results.pop_front();
				if (rsp.data_out !== want.data_out)
					log_mismatch("data_out", rsp.data_out, want.data_out);
				if (rsp.status !== want.status)
					log_mismatch("status", rsp.status, want.status);
				if (rsp.amount !== want.amount)
					log_mismatch("amount", rsp.amount, want.amount);
				if (rsp.occupancy !== want.occupancy)
					log_mismatch("occupancy", rsp.occupancy, want.occupancy);
				if (rsp.last !== want.last)
					log_mismatch("last", rsp.last, want.last);
			end
			results_checked++;
		end
	end

	// watchdog: too long without any transfer means the block is stuck
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// every operation and its corner cases at the reset size
	task automatic test_directed_ops();
		int k;
		gap_max = 0;
		rx_mode = RX_ALWAYS;
		send_op(ring_op(K_GET, 8'h00, 10'd5, 8'h00));      // get from empty
		send_op(ring_op(K_PUT, 8'h00, 10'd0, 8'h00));
		send_op(ring_op(K_PUT, 8'hFF, 10'd0, 8'h00));
		send_op(ring_op(K_PUT, 8'h80, 10'd0, 8'h00));
		send_op(ring_op(K_PUT, 8'h01, 10'd0, 8'h00));
		send_op(ring_op(K_SCAN, 8'h00, 10'd0, 8'h00));     // no stop byte
		send_op(ring_op(K_SCAN, 8'h00, 10'd0, 8'h80));
		send_op(ring_op(K_SCAN, 8'h00, 10'd0, 8'hFF));
		send_op(ring_op(K_GET, 8'h00, 10'd0, 8'h00));      // zero-count get
		send_op(ring_op(K_GET, 8'h00, 10'd1, 8'h00));
		send_op(ring_op(K_FLUSH, 8'h00, 10'd1, 8'h00));
		send_op(ring_op(K_GET, 8'h00, 10'd1023, 8'h00));   // clamped, runs dry
		send_op(ring_op(K_FLUSH, 8'h00, 10'd0, 8'h00));
		for (k = K_UNUSED_FIRST; k <= K_UNUSED_LAST; k++)
			send_op(ring_op(3'(k), 8'hFF, 10'd1023, 8'hFF));
		send_op(ring_op(K_PUT, 8'h5A, 10'd0, 8'h00));
		send_op(ring_op(K_PUT, 8'hA5, 10'd0, 8'h00));
		send_op(ring_op(K_FLUSH, 8'h00, 10'd1023, 8'h00)); // more than held
		send_op(ring_op(K_PUT, 8'h3C, 10'd0, 8'h00));
		send_op(ring_op(K_CLEAR, 8'h00, 10'd0, 8'h00));
	endtask

	// tiny store: fill to full, wrap the write point, scan up to the store end
	task automatic test_full_and_wrap();
		write_buffer_size(11'd4);
		send_op(ring_op(K_PUT, 8'h00, 10'd0, 8'h00));
		send_op(ring_op(K_PUT, 8'h40, 10'd0, 8'h00));
		send_op(ring_op(K_PUT, 8'h00, 10'd0, 8'h00));
		send_op(ring_op(K_PUT, 8'h99, 10'd0, 8'h00));      // full, not entered
		send_op(ring_op(K_GET, 8'h00, 10'd2, 8'h00));
		send_op(ring_op(K_PUT, 8'h02, 10'd0, 8'h00));
		send_op(ring_op(K_PUT, 8'h81, 10'd0, 8'h00));      // written at the store start, after the wrap
		send_op(ring_op(K_SCAN, 8'h00, 10'd0, 8'h00));
		send_op(ring_op(K_SCAN, 8'h00, 10'd0, 8'h02));
		send_op(ring_op(K_FLUSH, 8'h00, 10'd1023, 8'h00));
	endtask

	// phases of random traffic over a spread of sizes, extremes included
	task automatic test_random_traffic();
		logic [CFG_W-1:0] sizes [12];
		int               ph, i, fill_left;
		bit               fill_bias;
		sizes = '{11'd2047, 11'd1, 11'd2, 11'd3, 11'd5, 11'd16, 11'd1024, 11'd1025,
			11'd0, 11'd40, 11'd7, 11'd9};
		sizes[10] = 11'($urandom_range(2, 64));
		sizes[11] = 11'($urandom);
		for (ph = 0; ph < 12; ph++) begin
			write_buffer_size(sizes[ph]);
			gap_max    = (ph % 4 == 0) ? 0 : $urandom_range(1, 6);
			rx_mode    = (ph + 1) % 3;
			fill_bias  = 1'b1;
			fill_left  = $urandom_range(6, 30);
			burst_left = 0;
			for (i = 0; i < 30; i++) begin
				send_op(random_op(fill_bias));
				if (fill_left == 0) begin
					fill_bias = !fill_bias;
					fill_left = $urandom_range(6, 30);
				end else begin
					fill_left--;
				end
			end
		end
	endtask

	// receiver holds off for a long stretch while requests keep coming,
	// so the output register fills and the request side stalls
	task automatic test_output_hold_off();
		int i;
		write_buffer_size(11'd12);
		gap_max      = 0;
		rx_mode      = RX_ALWAYS;
		hold_request = 500;
		for (i = 0; i < 48; i++)
			send_op(random_op(i < 24));
		rx_mode = RX_RANDOM;
		for (i = 0; i < 12; i++)
			send_op(ring_op(K_GET, 8'h00, 10'($urandom_range(MAX_BURST, 1023)), 8'h00));
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_ops();
		test_full_and_wrap();
		test_random_traffic();
		test_output_hold_off();

		// final drain, then a quiet spell to catch stray results
		wait_drained();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && awaited_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ tty_char_ring_buffer.f @@
rtl/tcrb_pkg.sv
rtl/tcrb_alu.sv
rtl/tcrb_store.sv
rtl/tcrb_ctrl.sv
rtl/tty_char_ring_buffer.sv
tb/tb_tty_char_ring_buffer.sv
